>>> src/tdps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer descriptor page splitter package
// Shared widths, payload structs and page constants for the splitter.
// ----------------------------------------------------------------------------
package tdps_pkg;

   // Field widths of the request and the descriptor.
   localparam int ADDR_W = 32;
   localparam int LEN_W  = 16;
   localparam int MPS_W  = 11;

   // Page geometry and run limit.
   localparam int PAGE_BYTES      = 4096;
   localparam int PAGE_BITS       = $clog2(PAGE_BYTES);
   localparam int MAX_DESCRIPTORS = 10;
   localparam int CNT_W           = $clog2(MAX_DESCRIPTORS);

   // One descriptor spans at most two pages, so its length needs two extra bits.
   localparam int SPAN_W = PAGE_BITS + 2;
   localparam int CMP_W  = (SPAN_W > LEN_W) ? SPAN_W : LEN_W;
   localparam logic [SPAN_W-1:0] PAGE_SPAN = SPAN_W'(PAGE_BYTES);

   // Remainder unit: bits of the length retired per cycle.
   localparam int DIV_RADIX = 4;
   localparam int DIV_STEPS = LEN_W / DIV_RADIX;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Depth of the command queue between the front and the back.
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Incoming bulk transfer request.
   typedef struct packed {
      logic [ADDR_W-1:0] buffer_address;
      logic [LEN_W-1:0]  transfer_length;
      logic [MPS_W-1:0]  packet_size;
      logic              finalize;
      logic              dir_in;
   } req_type;

   // One general transfer descriptor.
   typedef struct packed {
      logic [ADDR_W-1:0] segment_start;
      logic [ADDR_W-1:0] segment_end;
      logic              zero_length;
      logic              td_dir_in;
      logic              write_done_head;
      logic              last;
   } rsp_type;

   // Classified request handed from the front to the back.
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic              dir_in;
      logic              add_zlp;
   } cmd_type;

endpackage

>>> src/transfer_descriptor_page_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer descriptor page splitter
// Splits a bulk transfer request into general transfer descriptors, each
// covering the rest of a page plus at most one more page, with an optional
// zero-length terminating descriptor.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Direction  Transfer when
//  request   req_push, req_full, req_data   in         req_push && !req_full
//  result    rsp_empty, rsp_pop, rsp_data   out        rsp_pop && !rsp_empty
//
//  The front captures a request, takes the packet-size remainder 4 length
//  bits per cycle, then hands it off once the queue has room; it takes no
//  new request until then. The back issues one descriptor per cycle while
//  the output is drained. A two-entry command queue separates the two, so a
//  stalled result side holds the front only once the queue is full. Reset
//  is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module transfer_descriptor_page_splitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  tdps_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tdps_pkg::rsp_type rsp_data
);
   import tdps_pkg::*;

   logic    front_valid;
   logic    queue_full;
   cmd_type front_cmd;
   logic    queue_empty;
   logic    back_pop;
   cmd_type queue_cmd;

   // Request capture and classification.
   tdps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_ready (!queue_full),
      .cmd_data  (front_cmd)
   );

   // Command queue between front and back.
   tdps_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .full      (queue_full),
      .push_data (front_cmd),
      .pop       (back_pop),
      .empty     (queue_empty),
      .pop_data  (queue_cmd)
   );

   // Descriptor generation.
   tdps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (queue_empty),
      .cmd_pop   (back_pop),
      .cmd_data  (queue_cmd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> src/tdps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer descriptor page splitter front end
// Accepts a request and decides whether a zero-length descriptor follows it,
// using a multi-cycle remainder of the length by the packet size.
// ----------------------------------------------------------------------------
module tdps_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  tdps_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output tdps_pkg::cmd_type cmd_data
);
   import tdps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HAND
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  shift_ff;
   logic [MPS_W-1:0]  mps_ff;
   logic [MPS_W-1:0]  part_ff;
   logic [STEP_W-1:0] step_ff;
   logic              fin_ff;
   logic              dir_ff;
   logic              zlp_ff;

   logic [MPS_W-1:0]  part_in;
   logic [LEN_W-1:0]  shift_in;
   logic [MPS_W:0]    trial;
   logic              aligned;

   // Several restoring remainder steps per cycle, one length bit each.
   always_comb begin
      part_in  = part_ff;
      shift_in = shift_ff;
      trial    = '0;
      for (int k = 0; k < DIV_RADIX; k++) begin
         trial    = {part_in, shift_in[LEN_W-1]};
         shift_in = {shift_in[LEN_W-2:0], 1'b0};
         if (trial >= {1'b0, mps_ff}) begin
            trial = trial - {1'b0, mps_ff};
         end
         part_in = trial[MPS_W-1:0];
      end
   end

   // A zero packet size never counts as aligned.
   assign aligned = (mps_ff != '0) && (part_in == '0);

   // Request sequencing and remainder registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_push) begin
                  state_ff <= ST_DIVIDE;
                  step_ff  <= '0;
                  addr_ff  <= req_data.buffer_address;
                  len_ff   <= req_data.transfer_length;
                  shift_ff <= req_data.transfer_length;
                  mps_ff   <= req_data.packet_size;
                  part_ff  <= '0;
                  fin_ff   <= req_data.finalize;
                  dir_ff   <= req_data.dir_in;
               end
            end
            ST_DIVIDE: begin
               part_ff  <= part_in;
               shift_ff <= shift_in;
               step_ff  <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  zlp_ff   <= fin_ff && aligned;
                  state_ff <= ST_HAND;
               end
            end
            ST_HAND: begin
               if (cmd_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_full          = (state_ff != ST_IDLE);
   assign cmd_valid         = (state_ff == ST_HAND);
   assign cmd_data.address  = addr_ff;
   assign cmd_data.length   = len_ff;
   assign cmd_data.dir_in   = dir_ff;
   assign cmd_data.add_zlp  = zlp_ff;

`ifndef NO_ASSERTIONS
   // A zero-length descriptor is only requested when finalize was set.
   a_zlp_needs_finalize: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_data.add_zlp |-> fin_ff)
      else $error("zero-length descriptor requested without finalize");

   // A zero-length descriptor is never requested for a zero packet size.
   a_zlp_needs_mps: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_data.add_zlp |-> mps_ff != '0)
      else $error("zero-length descriptor requested with zero packet size");

   // The handoff state is only reached after the last remainder step.
   a_hand_after_divide: assert property (@(posedge clock) disable iff (reset)
      $rose(cmd_valid) |-> $past(state_ff == ST_DIVIDE)
         && $past(step_ff) == STEP_W'(DIV_STEPS - 1))
      else $error("handoff without finished remainder");
`endif

endmodule

>>> src/tdps_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer descriptor page splitter command queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module tdps_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  tdps_pkg::cmd_type push_data,
   input  logic              pop,
   output logic              empty,
   output tdps_pkg::cmd_type pop_data
);
   import tdps_pkg::*;

   cmd_type              slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff;
   logic [CMD_PTR_W-1:0] rd_ptr_ff;
   logic [CMD_CNT_W-1:0] count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                         : wr_ptr_ff + CMD_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                         : rd_ptr_ff + CMD_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CMD_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CMD_CNT_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   // The fill count never passes the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CMD_CNT_W'(CMD_DEPTH))
      else $error("command queue count out of range");

   // Pointers agree with the count when the queue is empty.
   a_ptr_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> wr_ptr_ff == rd_ptr_ff)
      else $error("command queue pointers disagree while empty");

   // A push alone raises the count by one.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + CMD_CNT_W'(1))
      else $error("command queue count not advanced on push");
`endif

endmodule

>>> src/tdps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer descriptor page splitter back end
// Walks a classified request in spans of up to two pages, one descriptor per
// cycle while the output register has room, then the optional zero-length one.
// ----------------------------------------------------------------------------
module tdps_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  tdps_pkg::cmd_type cmd_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tdps_pkg::rsp_type rsp_data
);
   import tdps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DATA,
      ST_ZLP
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LEN_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              dir_ff;
   logic              zlp_ff;
   logic              out_valid_ff;
   rsp_type           out_ff;

   logic              can_load;
   logic              out_load;
   logic [SPAN_W-1:0] first_span;
   logic [SPAN_W-1:0] limit_span;
   logic [LEN_W-1:0]  take;
   logic [LEN_W-1:0]  rem_in;
   logic [ADDR_W-1:0] addr_in;
   logic [ADDR_W-1:0] seg_end;
   logic              at_cap;
   logic              data_last;

   assign can_load = !out_valid_ff || rsp_pop;
   assign cmd_pop  = (state_ff == ST_IDLE) && !cmd_empty;

   // A descriptor enters the output register whenever one is due and there is room.
   assign out_load = can_load && ((state_ff == ST_DATA) || (state_ff == ST_ZLP));

   // One descriptor: the rest of this page plus at most one whole page.
   always_comb begin
      first_span = PAGE_SPAN - SPAN_W'(addr_ff[PAGE_BITS-1:0]);
      limit_span = first_span + PAGE_SPAN;
      if (CMP_W'(rem_ff) <= CMP_W'(limit_span)) begin
         take = rem_ff;
      end else begin
         take = LEN_W'(limit_span);
      end
      rem_in    = rem_ff - take;
      addr_in   = addr_ff + ADDR_W'(take);
      seg_end   = addr_in - ADDR_W'(1);
      at_cap    = (cnt_ff == CNT_W'(MAX_DESCRIPTORS - 1));
      data_last = at_cap || ((rem_in == '0) && !zlp_ff);
   end

   // Descriptor sequencing and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         out_valid_ff <= out_load || (out_valid_ff && !rsp_pop);
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (!cmd_empty) begin
                  addr_ff <= cmd_data.address;
                  rem_ff  <= cmd_data.length;
                  dir_ff  <= cmd_data.dir_in;
                  zlp_ff  <= cmd_data.add_zlp;
                  if (cmd_data.length != '0) begin
                     state_ff <= ST_DATA;
                  end else if (cmd_data.add_zlp) begin
                     state_ff <= ST_ZLP;
                  end
               end
            end
            ST_DATA: begin
               if (can_load) begin
                  out_ff.segment_start   <= addr_ff;
                  out_ff.segment_end     <= seg_end;
                  out_ff.zero_length     <= 1'b0;
                  out_ff.td_dir_in       <= dir_ff;
                  out_ff.write_done_head <= data_last;
                  out_ff.last            <= data_last;
                  addr_ff                <= addr_in;
                  rem_ff                 <= rem_in;
                  cnt_ff                 <= cnt_ff + CNT_W'(1);
                  if (data_last) begin
                     state_ff <= ST_IDLE;
                  end else if (rem_in == '0) begin
                     state_ff <= ST_ZLP;
                  end
               end
            end
            ST_ZLP: begin
               if (can_load) begin
                  out_ff.segment_start   <= '0;
                  out_ff.segment_end     <= '0;
                  out_ff.zero_length     <= 1'b1;
                  out_ff.td_dir_in       <= dir_ff;
                  out_ff.write_done_head <= 1'b1;
                  out_ff.last            <= 1'b1;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef NO_ASSERTIONS
   // A zero-length descriptor carries null pointers and closes the run.
   a_zlp_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.zero_length |->
         out_ff.segment_start == '0 && out_ff.segment_end == '0 && out_ff.last)
      else $error("malformed zero-length descriptor");

   // Data segments are only walked while bytes remain.
   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA |-> rem_ff != '0)
      else $error("data state with no bytes left");

   // The run never reaches past the descriptor limit.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DESCRIPTORS - 1) || state_ff == ST_IDLE)
      else $error("descriptor count past the limit");

   // Each data descriptor covers at least one byte.
   a_seg_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA |-> take != '0)
      else $error("empty data descriptor");
`endif

endmodule

>>> test/transfer_descriptor_page_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer descriptor page splitter testbench
// Sends bulk transfer requests through the push/full queue port and checks
// every descriptor popped from the result queue, in order, against a
// descriptor run computed here for each accepted request. A directed set
// covers page edges, address wrap and the zero-length cases, then random
// requests follow. Both sides idle at random.
// ----------------------------------------------------------------------------
module transfer_descriptor_page_splitter_tb;

   import tdps_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_COUNT  = 200;
   localparam int DRAIN_CYCLES  = 32;
   localparam int STALL_LIMIT   = 1000;
   localparam int REPORT_LIMIT  = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   // Requests waiting to be sent and descriptors waiting to be popped.
   req_type pending_requests[$];
   rsp_type expected_descriptors[$];

   int mismatch_count = 0;
   int send_gap       = 0;
   int pop_gap        = 0;
   int idle_cycles    = 0;
   bit send_steady    = 1'b0;
   bit pop_steady     = 1'b0;

   transfer_descriptor_page_splitter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap(input bit steady);
      int unsigned roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Split one request into its descriptor run and queue the descriptors.
   function automatic void split_request(input req_type r);
      longint unsigned page_size;
      longint unsigned addr;
      longint unsigned remain;
      longint unsigned pages;
      longint unsigned count;
      longint unsigned head_bytes;
      longint unsigned tail_bytes;
      longint unsigned seg_start;
      longint unsigned seg_end;
      longint unsigned idx;
      rsp_type d;
      page_size = PAGE_BYTES;
      addr      = r.buffer_address;
      remain    = r.transfer_length;
      pages     = 0;
      if (remain != 0)
         pages = (addr + remain - 1) / page_size - addr / page_size + 1;
      count = (pages + 1) / 2;
      // A packet-aligned length with finalize gets an empty closing descriptor.
      if (r.finalize && r.packet_size != 0 && (remain % r.packet_size) == 0)
         count++;
      if (count > MAX_DESCRIPTORS)
         count = MAX_DESCRIPTORS;
      for (idx = 0; idx < count; idx++) begin
         d = '0;
         d.td_dir_in = r.dir_in;
         if (remain == 0) begin
            d.zero_length = 1'b1;
         end else begin
            // Rest of the current page, then at most one more page.
            seg_start  = addr;
            head_bytes = page_size - (addr % page_size);
            if (head_bytes >= remain) begin
               seg_end = addr + remain - 1;
               addr    = addr + remain;
               remain  = 0;
            end else begin
               remain     = remain - head_bytes;
               addr       = addr + head_bytes;
               tail_bytes = (remain > page_size) ? page_size : remain;
               seg_end    = addr + tail_bytes - 1;
               remain     = remain - tail_bytes;
               addr       = addr + tail_bytes;
            end
            d.segment_start = seg_start[ADDR_W-1:0];
            d.segment_end   = seg_end[ADDR_W-1:0];
         end
         if (idx == count - 1) begin
            d.write_done_head = 1'b1;
            d.last            = 1'b1;
         end
         expected_descriptors.push_back(d);
      end
   endfunction

   function automatic void queue_request(input logic [ADDR_W-1:0] addr,
                                         input logic [LEN_W-1:0] len,
                                         input logic [MPS_W-1:0] mps,
                                         input logic fin, input logic dir);
      req_type r;
      r.buffer_address  = addr;
      r.transfer_length = len;
      r.packet_size     = mps;
      r.finalize        = fin;
      r.dir_in          = dir;
      pending_requests.push_back(r);
   endfunction

   // Random request, biased toward page edges, the top of the address space
   // and packet-aligned lengths.
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      int unsigned packets;
      r.buffer_address = $urandom();
      pick = $urandom_range(0, 9);
      if (pick < 3)
         r.buffer_address[11:0] = 12'hFFF - 12'($urandom_range(0, 15));
      else if (pick == 3)
         r.buffer_address[31:16] = 16'hFFFF;
      else if (pick == 4)
         r.buffer_address[11:0] = '0;

      pick = $urandom_range(0, 19);
      if (pick == 0)
         r.packet_size = '0;
      else if (pick < 3)
         r.packet_size = '1;
      else if (pick < 8)
         r.packet_size = MPS_W'(8 << $urandom_range(0, 7));
      else
         r.packet_size = MPS_W'($urandom_range(1, 2047));

      pick = $urandom_range(0, 19);
      if (pick < 5) begin
         r.transfer_length = LEN_W'($urandom_range(1, 600));
      end else if (pick < 10) begin
         if (r.packet_size != 0) begin
            packets = $urandom_range(0, 65535 / r.packet_size);
            if ($urandom_range(0, 2) != 0 && packets > 24)
               packets = packets % 24;
            r.transfer_length = LEN_W'(packets * r.packet_size);
         end else begin
            r.transfer_length = LEN_W'($urandom_range(0, 4096));
         end
      end else if (pick < 14) begin
         r.transfer_length = LEN_W'($urandom_range(0, 12288));
      end else if (pick < 17) begin
         r.transfer_length = LEN_W'($urandom_range(0, 65535));
      end else if (pick == 17) begin
         r.transfer_length = '0;
      end else if (pick == 18) begin
         r.transfer_length = '1;
      end else begin
         r.transfer_length = LEN_W'(PAGE_BYTES * $urandom_range(1, 15));
      end
      r.finalize = ($urandom_range(0, 3) != 0);
      r.dir_in   = $urandom_range(0, 1);
      return r;
   endfunction

   // Request side: present the oldest pending request, idling between transfers.
   always @(posedge clock) begin : request_driver
      logic push_next;
      push_next = 1'b0;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            split_request(pending_requests.pop_front());
            if ($urandom_range(0, 24) == 0)
               send_steady = !send_steady;
            send_gap = pick_gap(send_steady);
         end
         if (send_gap > 0)
            send_gap--;
         else
            push_next = (pending_requests.size() != 0);
         req_push <= push_next;
         if (push_next)
            req_data <= pending_requests[0];
      end
   end

   // Result side: pop with random stalls and check each descriptor in order.
   always @(posedge clock) begin : descriptor_monitor
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_descriptors.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected descriptor start=%h end=%h zl=%b dir=%b wdh=%b last=%b",
                           $realtime, rsp_data.segment_start, rsp_data.segment_end,
                           rsp_data.zero_length, rsp_data.td_dir_in,
                           rsp_data.write_done_head, rsp_data.last);
            end else begin
               want = expected_descriptors.pop_front();
               if (rsp_data.segment_start   !== want.segment_start ||
                   rsp_data.segment_end     !== want.segment_end ||
                   rsp_data.zero_length     !== want.zero_length ||
                   rsp_data.td_dir_in       !== want.td_dir_in ||
                   rsp_data.write_done_head !== want.write_done_head ||
                   rsp_data.last            !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: descriptor mismatch", $realtime);
                     $display("   expected start=%h end=%h zl=%b dir=%b wdh=%b last=%b",
                              want.segment_start, want.segment_end, want.zero_length,
                              want.td_dir_in, want.write_done_head, want.last);
                     $display("   actual   start=%h end=%h zl=%b dir=%b wdh=%b last=%b",
                              rsp_data.segment_start, rsp_data.segment_end,
                              rsp_data.zero_length, rsp_data.td_dir_in,
                              rsp_data.write_done_head, rsp_data.last);
                  end
               end
            end
            if ($urandom_range(0, 29) == 0)
               pop_steady = !pop_steady;
            pop_gap = pick_gap(pop_steady);
         end
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog: too long without a transfer on either side ends the run.
   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : run_control
      int k;
      // Empty requests, with and without the closing descriptor.
      queue_request(32'h0000_1000, 16'd0, 11'd64, 1'b0, 1'b0);
      queue_request(32'h0000_1000, 16'd0, 11'd64, 1'b1, 1'b1);
      // Single byte, aligned to a one-byte packet.
      queue_request(32'h0000_0000, 16'd1, 11'd1, 1'b1, 1'b0);
      // Zero packet size never counts as aligned.
      queue_request(32'h0000_2000, 16'd64, 11'd0, 1'b1, 1'b1);
      // Exact page and two-page lengths, then one byte more.
      queue_request(32'h0000_0000, 16'd4096, 11'd512, 1'b1, 1'b0);
      queue_request(32'h0000_0000, 16'd8192, 11'd512, 1'b1, 1'b1);
      queue_request(32'h0000_0000, 16'd8193, 11'd512, 1'b1, 1'b0);
      // Start in mid-page and on the last byte of a page.
      queue_request(32'h0000_0800, 16'd4096, 11'd64, 1'b0, 1'b1);
      queue_request(32'h0000_0FFF, 16'd2, 11'd2, 1'b1, 1'b0);
      queue_request(32'h1234_5FFF, 16'd12289, 11'd1024, 1'b1, 1'b1);
      // Address wrap past the top of the address space, and a run just below it.
      queue_request(32'hFFFF_FFFF, 16'hFFFF, 11'h7FF, 1'b1, 1'b1);
      queue_request(32'hFFFF_F000, 16'd8192, 11'd8, 1'b1, 1'b0);
      queue_request(32'hFFFF_E800, 16'd6000, 11'd1000, 1'b1, 1'b1);
      // Full-length and odd-pattern runs; in the first the closing descriptor makes ten.
      queue_request(32'h0000_0123, 16'hFFFF, 11'd5, 1'b1, 1'b0);
      queue_request(32'h0000_0000, 16'hFFFF, 11'd1, 1'b1, 1'b1);
      queue_request(32'hAAAA_AAAA, 16'hFFFF, 11'd3, 1'b0, 1'b0);
      queue_request(32'h5555_5555, 16'h5555, 11'h555, 1'b1, 1'b1);
      queue_request(32'h0000_0000, 16'hFFFF, 11'h7FF, 1'b0, 1'b1);
      // Packet-aligned lengths without and with finalize.
      queue_request(32'h0001_0040, 16'd2048, 11'd1024, 1'b0, 1'b0);
      queue_request(32'h8000_0000, 16'd4095, 11'd1365, 1'b1, 1'b1);
      for (k = 0; k < RANDOM_COUNT; k++)
         pending_requests.push_back(random_request());

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || expected_descriptors.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
src/tdps_pkg.sv
src/tdps_front.sv
src/tdps_cmd_fifo.sv
src/tdps_back.sv
src/transfer_descriptor_page_splitter.sv
test/transfer_descriptor_page_splitter_tb.sv
